[rtl/lstr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lstr_pkg
// Types, codes and the CRC16 step shared by the telegram receiver.
// ----------------------------------------------------------------------------
package lstr_pkg;

	localparam logic [7:0]  BYTE_ACK = 8'h06;
	localparam logic [7:0]  BYTE_NAK = 8'h15;
	localparam logic [7:0]  BYTE_STX = 8'h02;
	localparam logic [15:0] CRC_POLY = 16'h8005;

	localparam logic [15:0] TIMEOUT_RESET = 16'd200;
	localparam logic [15:0] MAXLEN_RESET  = 16'd806;

	typedef enum logic [0:0] {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_DONE = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_HDR_TO  = 3'd1,
		ERR_BODY_TO = 3'd2,
		ERR_START   = 3'd3,
		ERR_LENGTH  = 3'd4
	} err_t;

	typedef enum logic [0:0] {
		REG_TIMEOUT = 1'b0,
		REG_MAXLEN  = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_ADDR  = 3'd1,
		PH_LENLO = 3'd2,
		PH_LENHI = 3'd3,
		PH_DATA  = 3'd4,
		PH_CKLO  = 3'd5,
		PH_CKHI  = 3'd6
	} phase_t;

	typedef struct packed {
		logic [0:0] op;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [15:0] byte_index;
		logic [7:0]  address;
		logic [15:0] length;
		logic [2:0]  error_code;
		logic [15:0] crc_computed;
		logic [15:0] crc_received;
		logic [0:0]  crc_match;
		logic [0:0]  last;
	} out_item_t;

	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [15:0] max_payload_len;
	} cfg_t;

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] prev,
		input logic [7:0] b);
		logic [15:0] c;
		c = {crc[14:0], 1'b0};
		if (crc[15]) begin
			c = c ^ CRC_POLY;
		end
		return c ^ {prev, b};
	endfunction

endpackage
`default_nettype wire

[rtl/lstr_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lstr_decoder
// Telegram state, CRC accumulation and per-item result generation.
// ----------------------------------------------------------------------------
module lstr_decoder import lstr_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       step,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output logic      res_valid,
	output out_item_t res
);

	phase_t      phase_q, phase_d;
	logic [15:0] count_q, count_d;
	logic [15:0] len_q, len_d;
	logic [7:0]  addr_q, addr_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  prev_q, prev_d;
	logic [7:0]  cklo_q, cklo_d;
	logic [15:0] idle_q, idle_d;

	logic        is_tick;
	logic [7:0]  b;
	logic        tick_live;
	logic [15:0] idle_inc;
	logic        expire;
	logic        in_header;
	logic [15:0] len_new;
	logic [15:0] count_inc;
	logic [15:0] crc_fed;
	logic [15:0] rx_crc;
	logic        skip_byte;

	assign is_tick   = (item.op == OP_TICK);
	assign b         = item.rx_byte;
	assign tick_live = (phase_q != PH_HUNT) && (cfg.timeout_ticks != '0);
	assign idle_inc  = (idle_q == 16'hffff) ? idle_q : idle_q + 16'd1;
	assign expire    = tick_live && (idle_inc >= cfg.timeout_ticks);
	assign in_header = (phase_q == PH_ADDR) || (phase_q == PH_LENLO) || (phase_q == PH_LENHI);
	assign len_new   = {b, len_q[7:0]};
	assign count_inc = count_q + 16'd1;
	assign crc_fed   = crc_step(crc_q, prev_q, b);
	assign rx_crc    = {b, cklo_q};
	assign skip_byte = (b == BYTE_ACK) || (b == BYTE_NAK);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (step) begin
			if (is_tick) begin
				if (expire) begin
					phase_d = PH_HUNT;
				end
			end else begin
				unique case (phase_q)
					PH_ADDR:  phase_d = PH_LENLO;
					PH_LENLO: phase_d = PH_LENHI;
					PH_LENHI: begin
						if (len_new > cfg.max_payload_len) begin
							phase_d = PH_HUNT;
						end else if (len_new == '0) begin
							phase_d = PH_CKLO;
						end else begin
							phase_d = PH_DATA;
						end
					end
					PH_DATA:  phase_d = (count_inc >= len_q) ? PH_CKLO : PH_DATA;
					PH_CKLO:  phase_d = PH_CKHI;
					PH_CKHI:  phase_d = PH_HUNT;
					default:  phase_d = (b == BYTE_STX) ? PH_ADDR : PH_HUNT;
				endcase
			end
		end
	end

	// datapath and result
	always_comb begin
		count_d   = count_q;
		len_d     = len_q;
		addr_d    = addr_q;
		crc_d     = crc_q;
		prev_d    = prev_q;
		cklo_d    = cklo_q;
		idle_d    = idle_q;
		res_valid = 1'b0;
		res       = '0;
		if (step) begin
			if (is_tick) begin
				if (tick_live) begin
					idle_d = idle_inc;
					if (expire) begin
						idle_d         = '0;
						res_valid      = 1'b1;
						res.kind       = KIND_ERR;
						res.address    = addr_q;
						res.length     = len_q;
						res.error_code = in_header ? ERR_HDR_TO : ERR_BODY_TO;
						res.last       = 1'b1;
					end
				end
			end else begin
				idle_d = '0;
				unique case (phase_q)
					PH_ADDR: begin
						addr_d = b;
						crc_d  = crc_fed;
						prev_d = b;
					end
					PH_LENLO: begin
						len_d  = {8'h00, b};
						crc_d  = crc_fed;
						prev_d = b;
					end
					PH_LENHI: begin
						len_d   = len_new;
						crc_d   = crc_fed;
						prev_d  = b;
						count_d = '0;
						if (len_new > cfg.max_payload_len) begin
							res_valid      = 1'b1;
							res.kind       = KIND_ERR;
							res.address    = addr_q;
							res.length     = len_new;
							res.error_code = ERR_LENGTH;
							res.last       = 1'b1;
						end
					end
					PH_DATA: begin
						crc_d          = crc_fed;
						prev_d         = b;
						count_d        = count_inc;
						res_valid      = 1'b1;
						res.kind       = KIND_DATA;
						res.data_byte  = b;
						res.byte_index = count_q;
						res.address    = addr_q;
						res.length     = len_q;
					end
					PH_CKLO: begin
						cklo_d = b;
					end
					PH_CKHI: begin
						res_valid        = 1'b1;
						res.kind         = KIND_DONE;
						res.address      = addr_q;
						res.length       = len_q;
						res.crc_computed = crc_q;
						res.crc_received = rx_crc;
						res.crc_match    = (crc_q == rx_crc);
						res.last         = 1'b1;
					end
					default: begin
						if (!skip_byte) begin
							if (b != BYTE_STX) begin
								res_valid      = 1'b1;
								res.kind       = KIND_ERR;
								res.error_code = ERR_START;
								res.last       = 1'b1;
							end else begin
								addr_d  = '0;
								len_d   = '0;
								count_d = '0;
								crc_d   = {8'h00, BYTE_STX};
								prev_d  = BYTE_STX;
								cklo_d  = '0;
							end
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
			len_q   <= '0;
			addr_q  <= '0;
			crc_q   <= '0;
			prev_q  <= '0;
			cklo_q  <= '0;
			idle_q  <= '0;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
			len_q   <= len_d;
			addr_q  <= addr_d;
			crc_q   <= crc_d;
			prev_q  <= prev_d;
			cklo_q  <= cklo_d;
			idle_q  <= idle_d;
		end
	end

endmodule
`default_nettype wire

[rtl/laser_scanner_telegram_receiver_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// laser_scanner_telegram_receiver_unit
// Parses scanner telegrams from serial bytes and timer ticks, emits payload
// bytes and a completion or error item with the CRC16 check.
// ----------------------------------------------------------------------------
// channel   signals                              item
// item      item_valid/item_ready/item           op, rx_byte
// result    result_valid/result_ready/result     payload, completion or error
// cfg       cfg_valid/cfg_ready/cfg_index/data   0 timeout_ticks, 1 max_len
//
// One item per cycle unless stalled: input register, one pass through the
// decoder logic, result register; an item's result appears the cycle after
// it leaves the input register. A held result stalls the input register
// only when it is full. No start-up sweep after reset; cfg is always ready.
// ----------------------------------------------------------------------------
module laser_scanner_telegram_receiver_unit import lstr_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  wire       result_ready,
	output out_item_t result,
	input  wire       cfg_valid,
	output logic      cfg_ready,
	input  reg_idx_t  cfg_index,
	input  wire [15:0] cfg_data
);

	logic      item_vld_s1;
	in_item_t  item_s1;
	logic      out_vld_q;
	out_item_t out_q;
	cfg_t      cfg_q;
	logic      out_free;
	logic      step;
	logic      res_valid;
	out_item_t res;

	assign out_free     = !out_vld_q || result_ready;
	assign step         = item_vld_s1 && out_free;
	assign item_ready   = !item_vld_s1 || out_free;
	assign cfg_ready    = 1'b1;
	assign result_valid = out_vld_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks   <= TIMEOUT_RESET;
			cfg_q.max_payload_len <= MAXLEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TIMEOUT: cfg_q.timeout_ticks   <= cfg_data;
				REG_MAXLEN:  cfg_q.max_payload_len <= cfg_data;
				default:     cfg_q                 <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (item_ready) begin
			item_vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	lstr_decoder u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(item_vld_s1 && !out_free) |=> item_vld_s1)
		else $error("input register dropped a stalled item");

	a_crc_match: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.kind == KIND_DONE) |->
		(result.crc_match == (result.crc_computed == result.crc_received)) && result.last)
		else $error("completion item with inconsistent checksum flag");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.kind == KIND_ERR) |->
		(result.error_code != ERR_NONE) && result.last)
		else $error("error item without error code");

endmodule
`default_nettype wire
